// ----- src/sorted_insertion_buffer_macros.svh -----
// ---------------------------------------------------------------------------
// sorted_insertion_buffer_macros.svh
// Assertion macros shared by the sorted insertion buffer.
// ---------------------------------------------------------------------------
`ifndef SORTED_INSERTION_BUFFER_MACROS_SVH
`define SORTED_INSERTION_BUFFER_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define SIB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define SIB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sib_pkg.sv -----
// ---------------------------------------------------------------------------
// sib_pkg
// Sizes, codes and the command/status bundles of the sorted insertion buffer.
// ---------------------------------------------------------------------------
package sib_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	// operation codes on the func field
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_ENTRY = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    do_insert;
		logic    load_status;
		status_t code;
		logic    load_entry;
		logic    clr_idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_last;
	} sts_t;

endpackage

// ----- src/sib_dpath.sv -----
// ---------------------------------------------------------------------------
// sib_dpath
// Row of compare-and-shift cells holding the sorted values, the fill count,
// the read-out index and the output word register.
// ---------------------------------------------------------------------------
module sib_dpath
	import sib_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [DATA_W-1:0] value,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	output logic signed [DATA_W-1:0] data,
	output logic                     last,
	output status_t                  status
);

	logic signed [DATA_W-1:0] entry_q [CAPACITY];
	logic        [CNT_W-1:0]  count_q;
	logic        [IDX_W-1:0]  idx_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     last_q;
	status_t                  status_q;
	logic        [CAPACITY-1:0] lt;

	// per cell: valid and strictly below the new value (a thermometer code)
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (entry_q[i] < value);
		end
	end

	// status towards the controller
	assign sts.full    = (count_q == CNT_W'(CAPACITY));
	assign sts.empty   = (count_q == '0);
	assign sts.at_last = ({1'b0, idx_q} + CNT_W'(1)) == count_q;

	// cells: keep if smaller, take the new value at the insertion point,
	// otherwise take the neighbour below
	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (!lt[i]) begin
					if (i == 0) begin
						entry_q[i] <= value;
					end else if (lt[i-1]) begin
						entry_q[i] <= value;
					end else begin
						entry_q[i] <= entry_q[i-1];
					end
				end
			end
		end
	end

	// fill count and read-out index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.load_entry) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			data_q   <= '0;
			last_q   <= 1'b1;
			status_q <= cmd.code;
		end else if (cmd.load_entry) begin
			data_q   <= entry_q[idx_q];
			last_q   <= sts.at_last;
			status_q <= STAT_ENTRY;
		end
	end

	assign data   = data_q;
	assign last   = last_q;
	assign status = status_q;

endmodule

// ----- src/sib_ctrl.sv -----
// ---------------------------------------------------------------------------
// sib_ctrl
// Controller: takes input words, steps the read-out and owns output valid.
// ---------------------------------------------------------------------------
module sib_ctrl
	import sib_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   in_acc;
	logic   load;

	// output register can take a word this cycle
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d         = state_q;
		cmd.do_insert   = 1'b0;
		cmd.load_status = 1'b0;
		cmd.code        = STAT_OK;
		cmd.load_entry  = 1'b0;
		cmd.clr_idx     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func == FUNC_INSERT) begin
						cmd.load_status = 1'b1;
						cmd.code        = sts.full ? STAT_FULL : STAT_OK;
						cmd.do_insert   = !sts.full;
					end else if (sts.empty) begin
						cmd.load_status = 1'b1;
						cmd.code        = STAT_EMPTY;
					end else begin
						cmd.clr_idx = 1'b1;
						state_d     = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					cmd.load_entry = 1'b1;
					if (sts.at_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign load = cmd.load_status || cmd.load_entry;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/sorted_insertion_buffer.sv -----
// ---------------------------------------------------------------------------
// sorted_insertion_buffer
// Bounded ascending store of signed 32-bit values with insert and read-out.
// ---------------------------------------------------------------------------
//  channel | signals                       | direction
//  --------+-------------------------------+----------
//  in      | in_valid in_ready func value  | into block
//  out     | out_valid out_ready data last | out of block
//          | status                        |
//
// An insert word is accepted and its status word sits in the output register
// on the next edge; the shift happens in the cell row.
// A read-out of n entries first clears the read index, then gives n words,
// one per cycle while the output is not stalled, through the single read port
// of the cell row; an empty store gives one word on the next edge.
// Reset empties the store at once; no clearing pass.
// Output stalls hold the output register; a new word is taken only in idle
// with the output register free or draining.
`include "sorted_insertion_buffer_macros.svh"

module sorted_insertion_buffer
	import sib_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] data,
	output logic                     last,
	output logic [1:0]               status
);

	cmd_t    cmd;
	sts_t    sts;
	status_t status_w;

	sib_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sib_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.cmd    (cmd),
		.sts    (sts),
		.data   (data),
		.last   (last),
		.status (status_w)
	);

	assign status = status_w;

	// an insert always answers with one closing status word next cycle
	`SIB_ASSERT_NEXT(a_insert_answer, in_valid && in_ready && (func == FUNC_INSERT), out_valid && last && (data == 0) && ((status == STAT_OK) || (status == STAT_FULL)), "insert did not answer with a status word")

	// only read-out entries may leave last low
	`SIB_ASSERT_NOW(a_notlast_entry, out_valid && !last, status == STAT_ENTRY, "non-final word is not a read-out entry")

	// status words carry zero data and close the item
	`SIB_ASSERT_NOW(a_status_word, out_valid && (status != STAT_ENTRY), last && (data == 0), "status word with data or without last")

	// a read-out streams without gaps until its last entry
	`SIB_ASSERT_NEXT(a_stream_on, out_valid && out_ready && !last, out_valid && (status == STAT_ENTRY), "gap in read-out stream")

endmodule
